// File: sv/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    // numerator width of the divider: |a| shifted left by the fraction bits
    localparam int NUM_W     = DATA_W + FRAC_BITS;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_CMP      = 4'd6,
        OP_INC      = 4'd7,
        OP_DEC      = 4'd8,
        OP_FROM_INT = 4'd9,
        OP_TO_INT   = 4'd10
    } t_op;

    // classified item as it travels from front to back
    typedef struct packed {
        logic              is_div;
        logic              neg;
        logic [DATA_W-1:0] res;
        logic              lt;
        logic              eq;
        logic              gt;
        logic              dz;
        logic [NUM_W-1:0]  nq;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] dv;
    } t_item;

    // one restoring division step: shift in a numerator bit, produce a quotient bit
    function automatic t_item div_step(input t_item s);
        t_item         o;
        logic [DATA_W:0] t;
        o = s;
        t = {s.rem, s.nq[NUM_W-1]};
        if (t >= {1'b0, s.dv}) begin
            o.rem = DATA_W'(t - {1'b0, s.dv});
            o.nq  = {s.nq[NUM_W-2:0], 1'b1};
        end else begin
            o.rem = t[DATA_W-1:0];
            o.nq  = {s.nq[NUM_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// File: sv/fpa_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fpa_req_if;
    logic                           valid;
    logic                           ready;
    logic [3:0]                     req_type;
    logic signed [fpa_pkg::DATA_W-1:0] operand_a;
    logic signed [fpa_pkg::DATA_W-1:0] operand_b;
    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic signed [fpa_pkg::DATA_W-1:0] result_value;
    logic                           less_flag;
    logic                           equal_flag;
    logic                           greater_flag;
    logic                           div_by_zero;
    modport source (output valid, result_value, less_flag, equal_flag, greater_flag,
                    div_by_zero, input ready);
    modport sink   (input valid, result_value, less_flag, equal_flag, greater_flag,
                    div_by_zero, output ready);
endinterface
`default_nettype wire

// File: sv/fpa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    fpa_req_if.sink            i_req,
    output fpa_pkg::t_item     o_item,
    output logic               o_valid,
    input  wire logic          i_ready
);
    logic                              r_v;
    fpa_pkg::t_item                    r_item;
    fpa_pkg::t_item                    n_item;
    logic signed [fpa_pkg::DATA_W-1:0] a;
    logic signed [fpa_pkg::DATA_W-1:0] b;
    logic signed [2*fpa_pkg::DATA_W-1:0] prod;
    logic signed [2*fpa_pkg::DATA_W-1:0] prod_sh;
    logic [fpa_pkg::DATA_W-1:0]        mag_a;
    logic [fpa_pkg::DATA_W-1:0]        mag_b;
    logic                              load;

    assign a = i_req.operand_a;
    assign b = i_req.operand_b;
    assign i_req.ready = !r_v || i_ready;
    assign load = i_req.valid && i_req.ready;

    // classify the item and work out every result but the quotient
    always_comb begin
        prod    = a * b;
        prod_sh = prod >>> fpa_pkg::FRAC_BITS;
        mag_a   = a[fpa_pkg::DATA_W-1] ? fpa_pkg::DATA_W'(-a) : a;
        mag_b   = b[fpa_pkg::DATA_W-1] ? fpa_pkg::DATA_W'(-b) : b;
        n_item        = '0;
        n_item.lt     = a < b;
        n_item.eq     = a == b;
        n_item.gt     = a > b;
        n_item.neg    = a[fpa_pkg::DATA_W-1] ^ b[fpa_pkg::DATA_W-1];
        n_item.nq     = {mag_a, {fpa_pkg::FRAC_BITS{1'b0}}};
        n_item.dv     = mag_b;
        unique case (fpa_pkg::t_op'(i_req.req_type))
            fpa_pkg::OP_ADD:      n_item.res = a + b;
            fpa_pkg::OP_SUB:      n_item.res = a - b;
            fpa_pkg::OP_MUL:      n_item.res = prod_sh[fpa_pkg::DATA_W-1:0];
            fpa_pkg::OP_DIV: begin
                n_item.is_div = (b != 0);
                n_item.dz     = (b == 0);
            end
            fpa_pkg::OP_MIN:      n_item.res = (a < b) ? a : b;
            fpa_pkg::OP_MAX:      n_item.res = (a > b) ? a : b;
            fpa_pkg::OP_INC:      n_item.res = a + 1;
            fpa_pkg::OP_DEC:      n_item.res = a - 1;
            fpa_pkg::OP_FROM_INT: n_item.res = a << fpa_pkg::FRAC_BITS;
            fpa_pkg::OP_TO_INT:   n_item.res = a >>> fpa_pkg::FRAC_BITS;
            default:              n_item.res = '0;
        endcase
    end

    // hold the classified item until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (load) begin
            r_v <= 1'b1;
        end else if (i_ready) begin
            r_v <= 1'b0;
        end
        if (load) begin
            r_item <= n_item;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_v;
endmodule
`default_nettype wire

// File: sv/fpa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fpa_pkg::t_item i_item,
    input  wire logic          i_valid,
    output logic               o_ready,
    output fpa_pkg::t_item     o_item,
    output logic               o_valid,
    input  wire logic          i_ready
);
    fpa_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // store the item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) && !i_ready |=> (r_cnt == 2'd2)) else $error("full queue lost an item");
endmodule
`default_nettype wire

// File: sv/fpa_back.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fpa_pkg::t_item i_item,
    input  wire logic          i_valid,
    output logic               o_ready,
    fpa_rsp_if.source          o_rsp
);
    localparam int LAST = fpa_pkg::NUM_W;

    logic           r_v [LAST+1];
    fpa_pkg::t_item r_s [LAST+1];
    logic           adv;
    logic [fpa_pkg::DATA_W-1:0] q;

    assign adv     = !r_v[LAST] || o_rsp.ready;
    assign o_ready = adv;

    // advance the valid bits of the divider pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) r_v[k] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= LAST; k++) r_v[k] <= r_v[k-1];
        end
    end

    // one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s[0] <= i_item;
            for (int k = 1; k <= LAST; k++) r_s[k] <= fpa_pkg::div_step(r_s[k-1]);
        end
    end

    // sign the quotient and pick the result
    assign q = r_s[LAST].nq[fpa_pkg::DATA_W-1:0];
    assign o_rsp.valid        = r_v[LAST];
    assign o_rsp.result_value = !r_s[LAST].is_div ? r_s[LAST].res :
                                r_s[LAST].neg ? -q : q;
    assign o_rsp.less_flag    = r_s[LAST].lt;
    assign o_rsp.equal_flag   = r_s[LAST].eq;
    assign o_rsp.greater_flag = r_s[LAST].gt;
    assign o_rsp.div_by_zero  = r_s[LAST].dz;

    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] |-> $onehot({r_s[LAST].lt, r_s[LAST].eq, r_s[LAST].gt}))
        else $error("compare flags not one-hot");
    a_dz_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[LAST] && r_s[LAST].dz |-> !r_s[LAST].is_div)
        else $error("zero divisor item routed to quotient");
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> r_v[LAST]) else $error("stalled result dropped");
endmodule
`default_nettype wire

// File: sv/fixed_point_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Payload
// i_req   | in  | req_type[3:0], operand_a[31:0], operand_b[31:0]
// o_rsp   | out | result_value[31:0], less/equal/greater flags, div_by_zero
//
// One item per cycle sustained while the output is not stalled, every opcode alike.
// Items pass through the front register, the queue and one divider
// stage per quotient bit (NUM_W = 32 + FRAC_BITS) of the divider pipeline.
// Synchronous active-low reset clears valid bits, queue pointers and queue count only.
// A stalled output freezes the divider pipeline; the two-entry queue lets the
// front keep accepting meanwhile, until the queue is full.
module fixed_point_alu (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpa_req_if.sink   i_req,
    fpa_rsp_if.source o_rsp
);
    fpa_pkg::t_item f_item;
    fpa_pkg::t_item q_item;
    logic           f_valid;
    logic           q_ready;
    logic           q_valid;
    logic           b_ready;

    fpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_item  (f_item),
        .o_valid (f_valid),
        .i_ready (q_ready)
    );

    fpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (f_item),
        .i_valid (f_valid),
        .o_ready (q_ready),
        .o_item  (q_item),
        .o_valid (q_valid),
        .i_ready (b_ready)
    );

    fpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (q_item),
        .i_valid (q_valid),
        .o_ready (b_ready),
        .o_rsp   (o_rsp)
    );
endmodule
`default_nettype wire

// File: tb/sv/fpa_alu_checker.sv
`timescale 1ns / 1ps
module fpa_alu_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fpa_req_if.sink  i_req_mon,
    fpa_rsp_if.sink  i_rsp_mon,
    output int       o_fail_count,
    output int       o_pending
);
    import fpa_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
    } t_alu_result;

    t_alu_result expected_results[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    // compute what the ALU returns for one operation
    function automatic t_alu_result alu_predict(input logic [3:0] op,
                                                input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        t_alu_result r;
        logic signed [63:0] wide;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        r.value = '0;
        r.lt = (a < b);
        r.eq = (a == b);
        r.gt = (a > b);
        r.dz = 1'b0;
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: begin
                wide    = 64'(a) * 64'(b);
                wide    = wide >>> FRAC_BITS;
                r.value = wide[31:0];
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    num = (a < 0) ? -64'(a) : 64'(a);
                    den = (b < 0) ? -64'(b) : 64'(b);
                    num = num << FRAC_BITS;
                    quo = num / den;
                    if ((a < 0) != (b < 0))
                        quo = -quo;
                    r.value = quo[31:0];
                end
            end
            OP_MIN:      r.value = (a < b) ? a : b;
            OP_MAX:      r.value = (a > b) ? a : b;
            OP_INC:      r.value = a + 32'sd1;
            OP_DEC:      r.value = a - 32'sd1;
            OP_FROM_INT: r.value = a << FRAC_BITS;
            OP_TO_INT:   r.value = a >>> FRAC_BITS;
            default:     r.value = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // predict on accepted requests, compare accepted results
    always @(posedge i_clk) begin
        t_alu_result got;
        t_alu_result want;
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (i_req_mon.valid && i_req_mon.ready)
                expected_results.push_back(alu_predict(i_req_mon.req_type,
                    i_req_mon.operand_a, i_req_mon.operand_b));
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got = {i_rsp_mon.result_value, i_rsp_mon.less_flag, i_rsp_mon.equal_flag,
                       i_rsp_mon.greater_flag, i_rsp_mon.div_by_zero};
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value)
                        report_mismatch($sformatf("value got %h want %h",
                                                  got.value, want.value));
                    if ({got.lt, got.eq, got.gt} !== {want.lt, want.eq, want.gt})
                        report_mismatch($sformatf("flags got %b%b%b want %b%b%b",
                            got.lt, got.eq, got.gt, want.lt, want.eq, want.gt));
                    if (got.dz !== want.dz)
                        report_mismatch($sformatf("div_by_zero got %b want %b",
                                                  got.dz, want.dz));
                end
            end
        end
    end
endmodule

// File: tb/sv/tb_fixed_point_alu.sv
`timescale 1ns / 1ps
module tb_fixed_point_alu;
    import fpa_pkg::*;

    localparam int RANDOM_ITEMS = 730;
    localparam int QUIET_ITEMS  = 120;
    localparam int WATCHDOG_MAX = 2000;
    localparam int DRAIN_CYCLES = NUM_W + 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   sink_quiet = 1'b0;

    fpa_req_if req_ch ();
    fpa_rsp_if rsp_ch ();

    fixed_point_alu dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink),
                         .o_rsp(rsp_ch.source));

    fpa_alu_checker checker_u (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_mon(req_ch.sink),
                               .i_rsp_mon(rsp_ch.sink), .o_fail_count(fail_count),
                               .o_pending(pending));

    always #5 i_clk = ~i_clk;

    initial begin
        req_ch.valid     = 1'b0;
        req_ch.req_type  = '0;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        rsp_ch.ready     = 1'b0;
    end

    // stall the result side in random bursts, none in the last part
    always @(posedge i_clk) begin
        int burst;
        if (!i_rst_n || sink_quiet) begin
            rsp_ch.ready <= i_rst_n;
        end else if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 16);
            rsp_ch.ready <= 1'b0;
            repeat (burst) @(posedge i_clk);
            rsp_ch.ready <= 1'b1;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_MAX) begin
            $display("fixed_point_alu regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return 32'($signed($urandom_range(0, 2047)) - 1024);
            4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    // present one item, after an optional random gap, and hold it until accepted
    task automatic send_item(input logic [3:0] op, input logic [31:0] a,
                             input logic [31:0] b, input bit gaps);
        int burst;
        if (gaps && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 16);
            req_ch.valid <= 1'b0;
            repeat (burst) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic go_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        int          wait_cycles;
        idle_cycles = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every opcode at the extremes, zero divisor, wrapping cases, unused opcodes
        for (int k = 0; k <= int'(OP_TO_INT); k++)
            send_item(4'(k), 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_item(OP_DIV, 32'h0000_0100, 32'h0000_0000, 1'b0);
        send_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b0);
        send_item(OP_DIV, 32'hffff_fd00, 32'h0000_0200, 1'b0);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_item(OP_MUL, 32'hffff_ff80, 32'h0000_0080, 1'b0);
        send_item(OP_MIN, 32'h0000_1234, 32'h0000_1234, 1'b0);
        send_item(OP_MAX, 32'h0000_1234, 32'h0000_1234, 1'b0);
        send_item(OP_CMP, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_item(OP_INC, 32'h7fff_ffff, 32'h0, 1'b0);
        send_item(OP_DEC, 32'h8000_0000, 32'h0, 1'b0);
        send_item(OP_TO_INT, 32'hffff_ffff, 32'h0, 1'b0);
        send_item(4'd11, 32'h1, 32'h2, 1'b0);
        send_item(4'd15, 32'hffff_ffff, 32'hffff_ffff, 1'b0);

        // hold off until every expected result is back
        go_idle();
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                sink_quiet = 1'b1;
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(0, 10));
            a = pick_operand();
            b = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand();
            if ($urandom_range(0, 15) == 0)
                b = a;
            send_item(op, a, b, n < RANDOM_ITEMS - QUIET_ITEMS);
        end
        go_idle();

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("fixed_point_alu regression: pass");
        else
            $display("fixed_point_alu regression: fail");
        $finish;
    end
endmodule
